FILE: sv/seeg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seeg_pkg
// Shared types, constants and arithmetic helpers of the event generator.
// ----------------------------------------------------------------------------
package seeg_pkg;

   localparam int DEF_MAX_DIMS = 4;
   localparam int VALUE_WIDTH  = 32;
   localparam logic [31:0] VALUE_MAX = (VALUE_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                       32'((64'd1 << VALUE_WIDTH) - 64'd1);

   localparam logic [31:0] LN2_Q32       = 32'd2977044472;
   localparam logic [32:0] LOG2E_Q32     = 33'd6196328019;
   localparam logic [47:0] EXP_CUTOFF    = 48'd1572864;
   localparam logic [31:0] HORIZON_RESET = 32'd6553600;
   localparam int          DIV_STEPS     = 38;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZON = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMS    = 1'b1;

   localparam logic [1:0] REQ_RESTART = 2'd0;
   localparam logic [1:0] REQ_COEF    = 2'd1;
   localparam logic [1:0] REQ_DRAW    = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_RST_INIT, OP_RST_STEP, OP_COEF_WR, OP_SET_FIN,
      OP_NORM_INIT, OP_NORM_STEP, OP_LOG, OP_LNMUL, OP_DIV_STEP, OP_ADVANCE,
      OP_DT_INIT, OP_FAC1, OP_FAC2, OP_FAC3, OP_FAC4, OP_LAM_STEP, OP_LAM_END,
      OP_TARGET, OP_REJECT, OP_PICK_INIT, OP_PICK_STEP, OP_UPD_INIT,
      OP_UPD_STEP, OP_COMMIT, OP_OUT_DONE, OP_OUT_EVT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_kind;
      logic       finished;
      logic       trivial;
      logic       norm_done;
      logic       div_last;
      logic       i_last;
      logic       j_last;
      logic       reject;
      logic       pick_hit;
      logic       out_free;
   } status_type;

   // log2(1+k/16), Q1.16
   function automatic logic [16:0] log2_tab(input logic [4:0] k);
      logic [16:0] v;
      unique case (k)
         5'd0:  v = 17'd0;
         5'd1:  v = 17'd5732;
         5'd2:  v = 17'd11136;
         5'd3:  v = 17'd16248;
         5'd4:  v = 17'd21098;
         5'd5:  v = 17'd25711;
         5'd6:  v = 17'd30109;
         5'd7:  v = 17'd34312;
         5'd8:  v = 17'd38336;
         5'd9:  v = 17'd42196;
         5'd10: v = 17'd45904;
         5'd11: v = 17'd49472;
         5'd12: v = 17'd52911;
         5'd13: v = 17'd56229;
         5'd14: v = 17'd59434;
         5'd15: v = 17'd62534;
         5'd16: v = 17'd65536;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   // 2^(-k/16), Q1.16
   function automatic logic [16:0] pow2n_tab(input logic [4:0] k);
      logic [16:0] v;
      unique case (k)
         5'd0:  v = 17'd65536;
         5'd1:  v = 17'd62757;
         5'd2:  v = 17'd60097;
         5'd3:  v = 17'd57549;
         5'd4:  v = 17'd55109;
         5'd5:  v = 17'd52773;
         5'd6:  v = 17'd50535;
         5'd7:  v = 17'd48393;
         5'd8:  v = 17'd46341;
         5'd9:  v = 17'd44376;
         5'd10: v = 17'd42495;
         5'd11: v = 17'd40693;
         5'd12: v = 17'd38968;
         5'd13: v = 17'd37316;
         5'd14: v = 17'd35734;
         5'd15: v = 17'd34219;
         5'd16: v = 17'd32768;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] sat64(input logic [63:0] v);
      return (v > {32'd0, VALUE_MAX}) ? VALUE_MAX : v[31:0];
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] s;
      s = {32'd0, a} + {32'd0, b};
      return sat64(s);
   endfunction

endpackage
`default_nettype wire

FILE: sv/seeg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seeg channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface seeg_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [4:0]  coef_index;
   logic [31:0] coef_value;
   logic [31:0] wait_uniform;
   logic [31:0] accept_uniform;
   modport source (output valid, req_type, coef_index, coef_value, wait_uniform,
                   accept_uniform, input ready);
   modport sink (input valid, req_type, coef_index, coef_value, wait_uniform,
                 accept_uniform, output ready);
endinterface

interface seeg_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] event_time;
   logic [1:0]  event_dim;
   logic        run_done;
   modport source (output valid, event_time, event_dim, run_done, input ready);
   modport sink (input valid, event_time, event_dim, run_done, output ready);
endinterface

interface seeg_csr_if;
   logic                           valid;
   logic                           ready;
   logic [seeg_pkg::CSR_IDX_W-1:0] reg_index;
   logic [31:0]                    write_data;
   modport source (output valid, reg_index, write_data, input ready);
   modport sink (input valid, reg_index, write_data, output ready);
endinterface
`default_nettype wire

FILE: sv/seeg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seeg_ctrl
// Sequencer: steps the datapath through restart, write and draw words.
// ----------------------------------------------------------------------------
module seeg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  seeg_pkg::status_type status,
   output seeg_pkg::cmd_type    cmd
);
   import seeg_pkg::*;

   typedef enum logic [21:0] {
      S_IDLE      = 22'd1 << 0,
      S_DECODE    = 22'd1 << 1,
      S_RST_SUM   = 22'd1 << 2,
      S_NORM      = 22'd1 << 3,
      S_LNMUL     = 22'd1 << 4,
      S_DIV       = 22'd1 << 5,
      S_ADVANCE   = 22'd1 << 6,
      S_CHECK     = 22'd1 << 7,
      S_FAC1      = 22'd1 << 8,
      S_FAC2      = 22'd1 << 9,
      S_FAC3      = 22'd1 << 10,
      S_FAC4      = 22'd1 << 11,
      S_LAM       = 22'd1 << 12,
      S_LAM_END   = 22'd1 << 13,
      S_TARGET    = 22'd1 << 14,
      S_TEST      = 22'd1 << 15,
      S_PICK      = 22'd1 << 16,
      S_UPD_INIT  = 22'd1 << 17,
      S_UPD       = 22'd1 << 18,
      S_UPD_END   = 22'd1 << 19,
      S_EMIT_DONE = 22'd1 << 20,
      S_EMIT_EVT  = 22'd1 << 21
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status.req_kind)
               REQ_RESTART: begin
                  cmd.op   = OP_RST_INIT;
                  state_in = S_RST_SUM;
               end
               REQ_COEF: begin
                  cmd.op   = OP_COEF_WR;
                  state_in = S_IDLE;
               end
               REQ_DRAW: begin
                  if (status.finished) begin
                     state_in = S_EMIT_DONE;
                  end else if (status.trivial) begin
                     cmd.op   = OP_SET_FIN;
                     state_in = S_EMIT_DONE;
                  end else begin
                     cmd.op   = OP_NORM_INIT;
                     state_in = S_NORM;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_RST_SUM: begin
            cmd.op = OP_RST_STEP;
            if (status.i_last) state_in = S_IDLE;
         end
         S_NORM: begin
            if (status.norm_done) begin
               cmd.op   = OP_LOG;
               state_in = S_LNMUL;
            end else begin
               cmd.op = OP_NORM_STEP;
            end
         end
         S_LNMUL: begin
            cmd.op   = OP_LNMUL;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (status.div_last) state_in = S_ADVANCE;
         end
         S_ADVANCE: begin
            cmd.op   = OP_ADVANCE;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (status.finished) begin
               state_in = S_EMIT_DONE;
            end else begin
               cmd.op   = OP_DT_INIT;
               state_in = S_FAC1;
            end
         end
         S_FAC1: begin
            cmd.op   = OP_FAC1;
            state_in = S_FAC2;
         end
         S_FAC2: begin
            cmd.op   = OP_FAC2;
            state_in = S_FAC3;
         end
         S_FAC3: begin
            cmd.op   = OP_FAC3;
            state_in = S_FAC4;
         end
         S_FAC4: begin
            cmd.op   = OP_FAC4;
            state_in = S_LAM;
         end
         S_LAM: begin
            cmd.op = OP_LAM_STEP;
            if (status.j_last) state_in = S_LAM_END;
         end
         S_LAM_END: begin
            cmd.op   = OP_LAM_END;
            state_in = status.i_last ? S_TARGET : S_FAC1;
         end
         S_TARGET: begin
            cmd.op   = OP_TARGET;
            state_in = S_TEST;
         end
         S_TEST: begin
            if (status.reject) begin
               cmd.op   = OP_REJECT;
               state_in = S_IDLE;
            end else begin
               cmd.op   = OP_PICK_INIT;
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            cmd.op = OP_PICK_STEP;
            if (status.pick_hit || status.i_last) state_in = S_UPD_INIT;
         end
         S_UPD_INIT: begin
            cmd.op   = OP_UPD_INIT;
            state_in = S_UPD;
         end
         S_UPD: begin
            cmd.op = OP_UPD_STEP;
            if (status.i_last && status.j_last) state_in = S_UPD_END;
         end
         S_UPD_END: begin
            cmd.op   = OP_COMMIT;
            state_in = S_EMIT_EVT;
         end
         S_EMIT_DONE: begin
            if (status.out_free) begin
               cmd.op   = OP_OUT_DONE;
               state_in = S_IDLE;
            end
         end
         S_EMIT_EVT: begin
            if (status.out_free) begin
               cmd.op   = OP_OUT_EVT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/seeg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seeg_datapath
// Coefficient tables, excess intensities, log/exp units, serial divider,
// accumulators and the response register.
// ----------------------------------------------------------------------------
module seeg_datapath #(
   parameter int MAX_DIMS = seeg_pkg::DEF_MAX_DIMS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  seeg_pkg::cmd_type              cmd,
   output seeg_pkg::status_type           status,
   input  logic [1:0]                     req_type,
   input  logic [4:0]                     coef_index,
   input  logic [31:0]                    coef_value,
   input  logic [31:0]                    wait_uniform,
   input  logic [31:0]                    accept_uniform,
   input  logic                           csr_we,
   input  logic [seeg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [31:0]                    event_time,
   output logic [1:0]                     event_dim,
   output logic                           run_done
);
   import seeg_pkg::*;

   localparam int DIM_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int ENTRIES = MAX_DIMS * MAX_DIMS;
   localparam int ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // architectural state
   logic [31:0] base_ff [MAX_DIMS];
   logic [31:0] base_in [MAX_DIMS];
   logic [31:0] decay_ff [MAX_DIMS];
   logic [31:0] decay_in [MAX_DIMS];
   logic [31:0] exc_ff [ENTRIES];
   logic [31:0] exc_in [ENTRIES];
   logic [31:0] excess_ff [ENTRIES];
   logic [31:0] excess_in [ENTRIES];
   logic [31:0] bound_ff, bound_in;
   logic [31:0] cand_ff, cand_in;
   logic [31:0] last_ff, last_in;
   logic [31:0] horizon_ff, horizon_in;
   logic [2:0]  dims_ff, dims_in;
   logic        finished_ff, finished_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [1:0]       kind_ff, kind_in;
   logic [4:0]       idx_ff, idx_in;
   logic [31:0]      cval_ff, cval_in;
   logic [31:0]      wu_ff, wu_in;
   logic [31:0]      au_ff, au_in;
   logic [31:0]      shift_ff, shift_in;
   logic [4:0]       lz_ff, lz_in;
   logic [16:0]      l2_ff, l2_in;
   logic [37:0]      quo_ff, quo_in;
   logic [32:0]      rem_ff, rem_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [31:0]      dt_ff, dt_in;
   logic [47:0]      x_ff, x_in;
   logic [21:0]      y_ff, y_in;
   logic             zf_ff, zf_in;
   logic [16:0]      g_ff, g_in;
   logic [32:0]      fac_ff [MAX_DIMS];
   logic [32:0]      fac_in [MAX_DIMS];
   logic [31:0]      lam_ff [MAX_DIMS];
   logic [31:0]      lam_in [MAX_DIMS];
   logic [DIM_W-1:0] i_ff, i_in;
   logic [DIM_W-1:0] j_ff, j_in;
   logic [DIM_W-1:0] pick_ff, pick_in;
   logic [31:0]      acc_ff, acc_in;
   logic [31:0]      total_ff, total_in;
   logic [31:0]      cum_ff, cum_in;
   logic [31:0]      nb_ff, nb_in;
   logic [63:0]      target_ff, target_in;
   logic [31:0]      otime_ff, otime_in;
   logic [1:0]       odim_ff, odim_in;
   logic             odone_ff, odone_in;

   // combinational helpers
   logic [DIM_W-1:0] dlast;
   logic [ENT_W-1:0] ent;
   logic             i_last, j_last;
   logic [64:0]      sc_prod;
   logic [31:0]      scaled;
   logic [31:0]      cum_n;
   logic             pick_hit;
   logic [16:0]      lt0, lt1, ldiff;
   logic [31:0]      lprod;
   logic [21:0]      nl2;
   logic [63:0]      ln_prod;
   logic [32:0]      rem_sh;
   logic             ge;
   logic [31:0]      w_sat, c_sum;
   logic [63:0]      dprod, yprod;
   logic [16:0]      p0, p1, pdiff;
   logic [31:0]      gprod;
   logic [5:0]       n_sh;
   logic [32:0]      fac_new;
   logic [31:0]      e_new, acc_n, cval_sat;
   logic [4:0]       doff, eoff;
   logic [2:0]       erow;
   logic [1:0]       ecol;

   always_comb begin
      if (dims_ff == 3'd0) begin
         dlast = '0;
      end else if (int'(dims_ff) > MAX_DIMS) begin
         dlast = DIM_W'(MAX_DIMS - 1);
      end else begin
         dlast = DIM_W'(dims_ff - 3'd1);
      end
   end

   assign i_last   = (i_ff == dlast);
   assign j_last   = (j_ff == dlast);
   assign ent      = ENT_W'(int'(i_ff) * MAX_DIMS + int'(j_ff));
   assign sc_prod  = 65'(excess_ff[ent]) * 65'(fac_ff[i_ff]);
   assign scaled   = sc_prod[63:32];
   assign cum_n    = sat_add(cum_ff, lam_ff[i_ff]);
   assign pick_hit = (target_ff <= {cum_n, 32'd0});

   // log2 interpolation
   assign lt0   = log2_tab({1'b0, shift_ff[30:27]});
   assign lt1   = log2_tab({1'b0, shift_ff[30:27]} + 5'd1);
   assign ldiff = lt1 - lt0;
   assign lprod = ldiff[15:0] * shift_ff[26:11];

   // -ln(u) = ln2 * -log2(u), rounded
   assign nl2     = {6'(lz_ff) + 6'd1, 16'd0} - {5'd0, l2_ff};
   assign ln_prod = 64'(nl2) * 64'(LN2_Q32) + 64'h8000_0000;

   // restoring divider step
   assign rem_sh = {rem_ff[31:0], quo_ff[37]};
   assign ge     = (rem_sh >= {1'b0, bound_ff});

   assign w_sat = sat64(64'(quo_ff));
   assign c_sum = sat64(64'(cand_ff) + 64'(w_sat));

   // exp(-x) pieces
   assign dprod   = 64'(decay_ff[i_ff]) * 64'(dt_ff);
   assign yprod   = 64'(x_ff[20:0]) * 64'(LOG2E_Q32);
   assign p0      = pow2n_tab({1'b0, y_ff[15:12]});
   assign p1      = pow2n_tab({1'b0, y_ff[15:12]} + 5'd1);
   assign pdiff   = p0 - p1;
   assign gprod   = pdiff[15:0] * {y_ff[11:0], 4'd0};
   assign n_sh    = y_ff[21:16];
   assign fac_new = (zf_ff || (n_sh >= 6'd32)) ? 33'd0 : ({g_ff, 16'd0} >> n_sh[4:0]);

   assign e_new = (j_ff == pick_ff) ? sat_add(scaled, exc_ff[ent]) : scaled;
   assign acc_n = sat_add(acc_ff, e_new);

   assign cval_sat = sat64(64'(cval_ff));
   assign doff     = idx_ff - 5'd4;
   assign eoff     = idx_ff - 5'd8;
   assign erow     = eoff[4:2];
   assign ecol     = eoff[1:0];

   always_comb begin
      base_in      = base_ff;
      decay_in     = decay_ff;
      exc_in       = exc_ff;
      excess_in    = excess_ff;
      bound_in     = bound_ff;
      cand_in      = cand_ff;
      last_in      = last_ff;
      horizon_in   = horizon_ff;
      dims_in      = dims_ff;
      finished_in  = finished_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      cval_in      = cval_ff;
      wu_in        = wu_ff;
      au_in        = au_ff;
      shift_in     = shift_ff;
      lz_in        = lz_ff;
      l2_in        = l2_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      dt_in        = dt_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      zf_in        = zf_ff;
      g_in         = g_ff;
      fac_in       = fac_ff;
      lam_in       = lam_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      pick_in      = pick_ff;
      acc_in       = acc_ff;
      total_in     = total_ff;
      cum_in       = cum_ff;
      nb_in        = nb_ff;
      target_in    = target_ff;
      otime_in     = otime_ff;
      odim_in      = odim_ff;
      odone_in     = odone_ff;

      if (csr_we) begin
         if (csr_index == CSR_HORIZON) horizon_in = csr_data;
         if (csr_index == CSR_DIMS) dims_in = csr_data[2:0];
      end

      case (cmd.op)
         OP_LATCH: begin
            kind_in = req_type;
            idx_in  = coef_index;
            cval_in = coef_value;
            wu_in   = wait_uniform;
            au_in   = accept_uniform;
         end
         OP_RST_INIT: begin
            for (int e = 0; e < ENTRIES; e++) excess_in[e] = '0;
            cand_in     = '0;
            last_in     = '0;
            finished_in = 1'b0;
            i_in        = '0;
            acc_in      = '0;
         end
         OP_RST_STEP: begin
            acc_in = sat_add(acc_ff, base_ff[i_ff]);
            if (i_last) begin
               bound_in = sat_add(acc_ff, base_ff[i_ff]);
            end else begin
               i_in = i_ff + DIM_W'(1);
            end
         end
         OP_COEF_WR: begin
            if (idx_ff < 5'd4) begin
               if (int'(idx_ff) < MAX_DIMS) base_in[DIM_W'(idx_ff)] = cval_sat;
            end else if (idx_ff < 5'd8) begin
               if (int'(doff) < MAX_DIMS) decay_in[DIM_W'(doff)] = cval_sat;
            end else if (idx_ff < 5'd24) begin
               if (int'(erow) < MAX_DIMS && int'(ecol) < MAX_DIMS) begin
                  exc_in[ENT_W'(int'(erow) * MAX_DIMS + int'(ecol))] = cval_sat;
               end
            end
         end
         OP_SET_FIN: finished_in = 1'b1;
         OP_NORM_INIT: begin
            shift_in = wu_ff;
            lz_in    = '0;
         end
         OP_NORM_STEP: begin
            shift_in = {shift_ff[30:0], 1'b0};
            lz_in    = lz_ff + 5'd1;
         end
         OP_LOG: l2_in = lt0 + {1'b0, lprod[31:16]};
         OP_LNMUL: begin
            quo_in = {ln_prod[53:32], 16'd0};
            rem_in = '0;
            cnt_in = '0;
         end
         OP_DIV_STEP: begin
            rem_in = ge ? (rem_sh - {1'b0, bound_ff}) : rem_sh;
            quo_in = {quo_ff[36:0], ge};
            cnt_in = cnt_ff + 6'd1;
         end
         OP_ADVANCE: begin
            cand_in     = c_sum;
            finished_in = (c_sum > horizon_ff);
         end
         OP_DT_INIT: begin
            dt_in    = (cand_ff >= last_ff) ? (cand_ff - last_ff) : 32'd0;
            i_in     = '0;
            total_in = '0;
         end
         OP_FAC1: x_in = dprod[63:16];
         OP_FAC2: begin
            zf_in = (x_ff > EXP_CUTOFF);
            y_in  = yprod[53:32];
         end
         OP_FAC3: g_in = p0 - {1'b0, gprod[31:16]};
         OP_FAC4: begin
            fac_in[i_ff] = fac_new;
            acc_in       = base_ff[i_ff];
            j_in         = '0;
         end
         OP_LAM_STEP: begin
            acc_in = sat_add(acc_ff, scaled);
            if (!j_last) j_in = j_ff + DIM_W'(1);
         end
         OP_LAM_END: begin
            lam_in[i_ff] = acc_ff;
            total_in     = sat_add(total_ff, acc_ff);
            if (!i_last) i_in = i_ff + DIM_W'(1);
         end
         OP_TARGET: target_in = 64'(au_ff) * 64'(bound_ff);
         OP_REJECT: bound_in = total_ff;
         OP_PICK_INIT: begin
            i_in    = '0;
            cum_in  = '0;
            pick_in = dlast;
         end
         OP_PICK_STEP: begin
            cum_in = cum_n;
            if (pick_hit) pick_in = i_ff;
            if (!i_last) i_in = i_ff + DIM_W'(1);
         end
         OP_UPD_INIT: begin
            i_in   = '0;
            j_in   = '0;
            nb_in  = '0;
            acc_in = base_ff[0];
         end
         OP_UPD_STEP: begin
            excess_in[ent] = e_new;
            if (j_last) begin
               nb_in = sat_add(nb_ff, acc_n);
               j_in  = '0;
               if (!i_last) begin
                  i_in   = i_ff + DIM_W'(1);
                  acc_in = base_ff[i_ff + DIM_W'(1)];
               end else begin
                  acc_in = acc_n;
               end
            end else begin
               acc_in = acc_n;
               j_in   = j_ff + DIM_W'(1);
            end
         end
         OP_COMMIT: begin
            bound_in = nb_ff;
            last_in  = cand_ff;
         end
         OP_OUT_DONE: begin
            rsp_valid_in = 1'b1;
            otime_in     = cand_ff;
            odim_in      = 2'd0;
            odone_in     = 1'b1;
         end
         OP_OUT_EVT: begin
            rsp_valid_in = 1'b1;
            otime_in     = cand_ff;
            odim_in      = 2'(pick_ff);
            odone_in     = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < MAX_DIMS; d++) begin
            base_ff[d]  <= '0;
            decay_ff[d] <= '0;
         end
         for (int e = 0; e < ENTRIES; e++) begin
            exc_ff[e]    <= '0;
            excess_ff[e] <= '0;
         end
         bound_ff     <= '0;
         cand_ff      <= '0;
         last_ff      <= '0;
         horizon_ff   <= HORIZON_RESET;
         dims_ff      <= 3'd1;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         decay_ff     <= decay_in;
         exc_ff       <= exc_in;
         excess_ff    <= excess_in;
         bound_ff     <= bound_in;
         cand_ff      <= cand_in;
         last_ff      <= last_in;
         horizon_ff   <= horizon_in;
         dims_ff      <= dims_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      idx_ff    <= idx_in;
      cval_ff   <= cval_in;
      wu_ff     <= wu_in;
      au_ff     <= au_in;
      shift_ff  <= shift_in;
      lz_ff     <= lz_in;
      l2_ff     <= l2_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      dt_ff     <= dt_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      zf_ff     <= zf_in;
      g_ff      <= g_in;
      fac_ff    <= fac_in;
      lam_ff    <= lam_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      pick_ff   <= pick_in;
      acc_ff    <= acc_in;
      total_ff  <= total_in;
      cum_ff    <= cum_in;
      nb_ff     <= nb_in;
      target_ff <= target_in;
      otime_ff  <= otime_in;
      odim_ff   <= odim_in;
      odone_ff  <= odone_in;
   end

   assign status.req_kind  = kind_ff;
   assign status.finished  = finished_ff;
   assign status.trivial   = (bound_ff == 32'd0) || (wu_ff == 32'd0);
   assign status.norm_done = shift_ff[31];
   assign status.div_last  = (cnt_ff == 6'(DIV_STEPS - 1));
   assign status.i_last    = i_last;
   assign status.j_last    = j_last;
   assign status.reject    = (target_ff > {total_ff, 32'd0});
   assign status.pick_hit  = pick_hit;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign event_time = otime_ff;
   assign event_dim  = odim_ff;
   assign run_done   = odone_ff;

endmodule
`default_nettype wire

FILE: sv/self_exciting_event_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// self_exciting_event_generator
// Multivariate Hawkes event generator (exponential kernels, thinning).
// ----------------------------------------------------------------------------
// One word is handled at a time. A restart walks the dimensions in use (d).
// A draw that finishes the run at once goes straight to the response slot; a
// full draw normalizes wait_uniform, whose L (0..31) leading zeros are walked
// one bit a cycle by the normalizer, takes the logarithm, runs the bit-serial
// divider and then gives each dimension a decay-factor pass plus d excess
// terms. An accepted candidate then takes the attribution walk and the d*d
// excess-intensity updates before the response slot; a rejected one ends
// without a response. The response register lets the next word be taken
// while a result waits.
// ----------------------------------------------------------------------------
module self_exciting_event_generator #(
   parameter int MAX_DIMS = seeg_pkg::DEF_MAX_DIMS
) (
   input logic        clock,
   input logic        reset,
   seeg_req_if.sink   req_chan,
   seeg_rsp_if.source rsp_chan,
   seeg_csr_if.sink   csr_chan
);
   import seeg_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   seeg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   seeg_datapath #(
      .MAX_DIMS (MAX_DIMS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req_chan.req_type),
      .coef_index     (req_chan.coef_index),
      .coef_value     (req_chan.coef_value),
      .wait_uniform   (req_chan.wait_uniform),
      .accept_uniform (req_chan.accept_uniform),
      .csr_we         (csr_chan.valid),
      .csr_index      (csr_chan.reg_index),
      .csr_data       (csr_chan.write_data),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .event_time     (rsp_chan.event_time),
      .event_dim      (rsp_chan.event_dim),
      .run_done       (rsp_chan.run_done)
   );

endmodule
`default_nettype wire
